FILE: hdl/bis_pkg.sv
// ----------------------------------------------------------------------------
// bis_pkg: shared types for the batch integer sorter
// Holds the data word, the link between neighbouring cells and the control
// word that the top level drives to every cell of the chain.
// ----------------------------------------------------------------------------
package bis_pkg;

  localparam int WORD_W = 32;

  typedef logic signed [WORD_W-1:0] word_t;

  // What one cell shows to its neighbours
  typedef struct packed {
    word_t val;   // held value
    logic  vld;   // cell holds a value of the current batch
    logic  take;  // cell takes part in the current insertion
  } cell_link_t;

  // Broadcast control for the whole chain
  typedef struct packed {
    logic  ins;   // insert x this cycle
    logic  shl;   // shift the chain one place towards cell 0
    word_t x;     // value being inserted
  } cell_ctrl_t;

endpackage

FILE: hdl/bis_in_if.sv
// ----------------------------------------------------------------------------
// bis_in_if: input channel of the batch integer sorter
// Valid/ready handshake carrying one value and the batch-closing mark.
// ----------------------------------------------------------------------------
interface bis_in_if import bis_pkg::*;;
  logic  valid;
  logic  ready;
  word_t value;
  logic  last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

FILE: hdl/bis_out_if.sv
// ----------------------------------------------------------------------------
// bis_out_if: result channel of the batch integer sorter
// Valid/ready handshake carrying one sorted value with its flags.
// ----------------------------------------------------------------------------
interface bis_out_if import bis_pkg::*;;
  logic  valid;
  logic  ready;
  word_t sorted_value;
  logic  final_res;
  logic  overflow;

  modport source (output valid, output sorted_value, output final_res, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input final_res, input overflow,
                  output ready);
endinterface

FILE: hdl/bis_cell.sv
// ----------------------------------------------------------------------------
// bis_cell: one cell of the systolic insertion chain
// Holds one value. On insert it keeps its value, takes the broadcast value or
// takes its left neighbour's value; on shift it takes its right neighbour's.
// ----------------------------------------------------------------------------
module bis_cell import bis_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  cell_link_t left,
  input  cell_link_t right,
  output cell_link_t link
);

  word_t val;
  logic  vld;
  logic  take;

  // Empty cells and cells holding a strictly larger value make room
  assign take = !vld || ($signed(val) > $signed(ctrl.x));

  assign link.val  = val;
  assign link.vld  = vld;
  assign link.take = take;

  // Advance the valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ctrl.ins && take) begin
      vld <= left.take ? left.vld : 1'b1;
    end else if (ctrl.shl) begin
      vld <= right.vld;
    end
  end

  // Advance the held value
  always_ff @(posedge clk) begin
    if (ctrl.ins && take) begin
      val <= left.take ? left.val : ctrl.x;
    end else if (ctrl.shl) begin
      val <= right.val;
    end
  end

endmodule

FILE: hdl/batch_integer_sorter.sv
// ----------------------------------------------------------------------------
// batch_integer_sorter: sorts batches of signed 32-bit integers
// A chain of CAPACITY cells keeps the batch in ascending order as it arrives;
// the closed batch is then shifted out of cell 0, smallest value first.
// ----------------------------------------------------------------------------
// Use:
//   items   : one value per transaction; last = 1 closes the batch.
//   results : the batch in ascending order, one value per transaction,
//             final_res on the last one, overflow on all of them when the
//             batch held more than CAPACITY values (the surplus is dropped).
// Throughput: one item accepted per cycle while a batch is filling, since
//   every cell compares against the broadcast value in parallel. After the
//   closing item the first result is valid in the next cycle and one result
//   leaves per cycle while the receiver is ready; filling and draining of a
//   batch do not overlap, as every result leaves by the single port at cell 0.
// items.ready is low while a batch drains; the next batch starts the cycle
//   after the final result is taken.
// Stalls: when results.ready is low the chain holds and the result stays.
// Reset: rst (synchronous) empties every cell and clears the overflow flag;
//   the block is ready for items in the next cycle.
// ----------------------------------------------------------------------------
module batch_integer_sorter import bis_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input logic     clk,
  input logic     rst,
  bis_in_if.sink  items,
  bis_out_if.source results
);

  localparam logic ST_FILL  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic          state;
  logic          state_next;
  logic          dropped;
  logic          dropped_next;
  logic          full;
  logic          in_fire;
  logic          out_fire;
  cell_ctrl_t    ctrl;
  cell_link_t    links    [CAPACITY];
  cell_link_t    left_in  [CAPACITY];
  cell_link_t    right_in [CAPACITY];
  logic [CAPACITY-1:0] vld_vec;

  assign full     = links[CAPACITY-1].vld;
  assign in_fire  = items.valid && items.ready;
  assign out_fire = results.valid && results.ready;

  // Broadcast control to the chain
  assign ctrl.ins = in_fire && !full;
  assign ctrl.shl = out_fire;
  assign ctrl.x   = items.value;

  // Wire neighbours, with fixed ends at both sides of the chain
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (i == 0) begin
        left_in[i] = '{val: ctrl.x, vld: 1'b0, take: 1'b0};
      end else begin
        left_in[i] = links[i-1];
      end
      if (i == CAPACITY - 1) begin
        right_in[i] = '{val: ctrl.x, vld: 1'b0, take: 1'b1};
      end else begin
        right_in[i] = links[i+1];
      end
      vld_vec[i] = links[i].vld;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    bis_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .left  (left_in[g]),
      .right (right_in[g]),
      .link  (links[g])
    );
  end

  // Fill until the closing item, drain until the final result leaves
  always_comb begin
    state_next   = state;
    dropped_next = dropped;
    unique case (state)
      ST_FILL: begin
        if (in_fire && full) begin
          dropped_next = 1'b1;
        end
        if (in_fire && items.last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_fire && results.final_res) begin
          state_next   = ST_FILL;
          dropped_next = 1'b0;
        end
      end
      default: begin
        state_next = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_FILL;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      dropped <= dropped_next;
    end
  end

  // Drive the channels
  assign items.ready          = (state == ST_FILL);
  assign results.valid        = (state == ST_DRAIN) && links[0].vld;
  assign results.sorted_value = links[0].val;
  assign results.final_res    = !links[1].vld;
  assign results.overflow     = dropped;

`ifndef SYNTHESIS
  // Occupied cells always form a run from cell 0
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    (vld_vec & (vld_vec + 1'b1)) == '0)
    else $error("cell occupancy is not contiguous");

  // The head of the chain never exceeds its neighbour while draining
  a_order: assert property (@(posedge clk) disable iff (rst)
    results.valid && links[1].vld |-> $signed(links[0].val) <= $signed(links[1].val))
    else $error("chain head out of order");

  // Input and output sides are never open together
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(items.ready && results.valid))
    else $error("input accepted while results pending");

  // Taking the final result empties the chain and reopens the input
  a_reopen: assert property (@(posedge clk) disable iff (rst)
    out_fire && results.final_res |=> items.ready && !links[0].vld && !dropped)
    else $error("batch not closed after final result");

  // Overflow flag holds steady through a drain
  a_ovf: assert property (@(posedge clk) disable iff (rst)
    results.valid && $past(results.valid) && !$past(rst) |-> $stable(dropped))
    else $error("overflow changed during drain");
`endif

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the batch integer sorter
// Feeds batches of signed values, some of them past capacity, and predicts
// each closed batch in ascending order with its final and overflow flags.
// Both channels idle at random, and each result is compared field by field.
// ----------------------------------------------------------------------------
module testbench import bis_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int    CAPACITY   = 64;
  localparam int    RAND_ITEMS = 410;
  localparam int    LIMIT      = 200000;
  localparam word_t WORD_MAX   = 32'sh7fff_ffff;
  localparam word_t WORD_MIN   = 32'sh8000_0000;

  typedef struct {
    word_t value;
    bit    fin;
    bit    ovf;
  } sorted_word_t;

  // Predicts the sorted output of each batch and checks results against it
  class sorted_batch_board;
    int           capacity;
    word_t        batch_vals[$];
    bit           batch_dropped;
    sorted_word_t pending_sorted[$];
    int           mismatches;

    function new(int cap);
      capacity      = cap;
      batch_dropped = 1'b0;
      mismatches    = 0;
    endfunction

    // Store or drop the value; on the closing transaction sort and queue the batch
    function void note_item(word_t v, bit is_last);
      word_t        held;
      int           i;
      int           j;
      sorted_word_t want;
      if (batch_vals.size() < capacity) begin
        batch_vals.push_back(v);
      end else begin
        batch_dropped = 1'b1;
      end
      if (!is_last) return;
      // insertion sort, signed ascending
      for (i = 1; i < batch_vals.size(); i++) begin
        held = batch_vals[i];
        j    = i;
        while (j > 0 && batch_vals[j-1] > held) begin
          batch_vals[j] = batch_vals[j-1];
          j--;
        end
        batch_vals[j] = held;
      end
      for (i = 0; i < batch_vals.size(); i++) begin
        want.value = batch_vals[i];
        want.fin   = (i == batch_vals.size() - 1);
        want.ovf   = batch_dropped;
        pending_sorted.push_back(want);
      end
      batch_vals.delete();
      batch_dropped = 1'b0;
    endfunction

    // Compare one result transaction with the oldest expectation
    function void check_result(word_t v, bit fin, bit ovf);
      sorted_word_t want;
      if (pending_sorted.size() == 0) begin
        $display("%0t: unexpected result value %0d final %0b overflow %0b",
                 $realtime, v, fin, ovf);
        mismatches++;
        return;
      end
      want = pending_sorted.pop_front();
      if (v !== want.value) begin
        $display("%0t: sorted_value expected %0d actual %0d", $realtime, want.value, v);
        mismatches++;
      end
      if (fin !== want.fin) begin
        $display("%0t: final_res expected %0b actual %0b", $realtime, want.fin, fin);
        mismatches++;
      end
      if (ovf !== want.ovf) begin
        $display("%0t: overflow expected %0b actual %0b", $realtime, want.ovf, ovf);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycle_count = 0;
  int   items_sent  = 0;

  sorted_batch_board board;

  bis_in_if  items_ch ();
  bis_out_if results_ch ();

  batch_integer_sorter #(.CAPACITY(CAPACITY)) uut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Give up on a hung run
  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("testbench failed");
    $finish;
  end

  // Stall the result channel now and then, apart from one quiet stretch
  initial begin
    results_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      results_ch.ready <= (cycle_count >= 500 && cycle_count < 1100) ||
                          ($urandom_range(99) >= 12);
    end
  end

  // Check every result transaction
  always @(posedge clk) begin
    if (!rst && results_ch.valid && results_ch.ready) begin
      board.check_result(results_ch.sorted_value, results_ch.final_res, results_ch.overflow);
    end
  end

  // Pick a value: full range, a narrow band for ties, extremes, or mid-range
  function automatic word_t pick_value();
    int mode;
    mode = $urandom_range(99);
    if (mode < 40) return word_t'($urandom);
    if (mode < 65) return word_t'($signed($urandom_range(16)) - 8);
    if (mode < 75) begin
      case ($urandom_range(3))
        0: return WORD_MIN;
        1: return WORD_MAX;
        2: return word_t'(0);
        default: return word_t'(-1);
      endcase
    end
    return word_t'($signed($urandom_range(2000)) - 1000);
  endfunction

  // Offer one item, with an occasional gap, and hold it until accepted
  task automatic push_item(input word_t v, input bit is_last);
    while (!(items_sent >= 120 && items_sent < 240) && $urandom_range(99) < 12) begin
      items_ch.valid <= 1'b0;
      @(negedge clk);
    end
    items_ch.valid <= 1'b1;
    items_ch.value <= v;
    items_ch.last  <= is_last;
    @(posedge clk);
    while (!items_ch.ready) @(posedge clk);
    board.note_item(v, is_last);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_batch(input int n);
    int k;
    for (k = 0; k < n; k++) begin
      push_item(pick_value(), k == n - 1);
    end
  endtask

  initial begin
    word_t dir_vals[$];
    bit    dir_last[$];
    int    i;
    int    pick;
    int    n;
    board            = new(CAPACITY);
    items_ch.valid   = 1'b0;
    items_ch.value   = '0;
    items_ch.last    = 1'b0;
    rst              = 1'b1;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed: single-value batches at the extremes, mixed signs with ties,
    // a descending run and repeated extremes
    dir_vals = {WORD_MAX, WORD_MIN,
                word_t'(0), word_t'(-1), word_t'(1), WORD_MAX, WORD_MIN,
                word_t'(5), word_t'(5), word_t'(-5),
                word_t'(100), word_t'(50), word_t'(0), word_t'(-50), word_t'(-100),
                WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX};
    dir_last = {1'b1, 1'b1,
                1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                1'b0, 1'b0, 1'b0, 1'b1};
    for (i = 0; i < dir_vals.size(); i++) begin
      push_item(dir_vals[i], dir_last[i]);
    end

    // Full store exactly, closing item dropped, and a batch well past capacity
    send_batch(CAPACITY);
    send_batch(CAPACITY + 1);
    send_batch(CAPACITY + 3);

    // Random batches, mostly short
    while (items_sent < RAND_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        n = $urandom_range(12, 1);
      end else if (pick < 85) begin
        n = $urandom_range(CAPACITY, CAPACITY - 4);
      end else begin
        n = $urandom_range(CAPACITY + 8, CAPACITY + 1);
      end
      send_batch(n);
    end
    items_ch.valid <= 1'b0;

    // Drain outstanding results, then allow a few idle cycles
    while (board.pending_sorted.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (board.mismatches == 0 && board.pending_sorted.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/bis_pkg.sv
hdl/bis_in_if.sv
hdl/bis_out_if.sv
hdl/bis_cell.sv
hdl/batch_integer_sorter.sv
verif/testbench.sv
